[hw/rtl/tfpb_pkg.sv]
// Shared types, constants and helpers for the tilt filter / PD balance block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfpb_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_BLEND_WEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT_ANGLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE_BAND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_GAIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GYRO_GAIN      = 3'd6;

   // register reset values
   localparam logic [15:0]        RST_BLEND_WEIGHT   = 16'd45875;
   localparam logic signed [31:0] RST_SETPOINT_ANGLE = 32'sd131;
   localparam logic [30:0]        RST_TOLERANCE_BAND = 31'd131;
   localparam logic [23:0]        RST_PROP_GAIN      = 24'd256000;
   localparam logic [23:0]        RST_DERIV_GAIN     = 24'd1280000;
   localparam logic [23:0]        RST_ACCEL_GAIN     = 24'd265900;
   localparam logic [23:0]        RST_GYRO_GAIN      = 24'd5721;

   // shared multiply-accumulate unit widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] I64_OF_I32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] I64_OF_I32_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_ACCEL,
      ST_MUL_GYRO,
      ST_MUL_BLEND_ACC,
      ST_MUL_BLEND_GYR,
      ST_SUM_BLEND,
      ST_ANGLE,
      ST_ERR,
      ST_MUL_PROP,
      ST_MUL_DERIV,
      ST_SUM_DRIVE,
      ST_DRIVE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MS_ACCEL,
      MS_GYRO,
      MS_BLEND_ACC,
      MS_BLEND_GYR,
      MS_PROP,
      MS_DERIV
   } mul_sel_type;

   typedef enum logic [1:0] {
      AO_HOLD,
      AO_LOAD,
      AO_ADD
   } acc_op_type;

   typedef struct packed {
      logic        idle;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        ld_accel;
      logic        ld_gyro;
      logic        ld_angle;
      logic        ld_err;
      logic        ld_diff;
      logic        ld_drive;
      logic        ld_out;
   } ctrl_type;

   // clamp a sign-extended value into 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > I64_OF_I32_MAX) begin
         r = I32_MAX;
      end else if (x < I64_OF_I32_MIN) begin
         r = I32_MIN;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/tfpb_mac.sv]
// Shared signed multiply-accumulate unit: registered product, then accumulator.
// Depends on tfpb_pkg for widths and the accumulator op codes.
`timescale 1ns / 1ps

module tfpb_mac
   import tfpb_pkg::*;
(
   input  logic                       clock,
   input  logic                       mul_en,
   input  acc_op_type                 acc_op,
   input  logic signed [MUL_A_W-1:0]  op_a,
   input  logic signed [MUL_B_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]   prod,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in = mul_en ? op_a * op_b : prod_ff;
   end

   always_comb begin
      case (acc_op)
         AO_LOAD: acc_in = {prod_ff[PROD_W-1], prod_ff};
         AO_ADD:  acc_in = acc_ff + {prod_ff[PROD_W-1], prod_ff};
         AO_HOLD: acc_in = acc_ff;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

[hw/rtl/tfpb_ctrl.sv]
// Sequencer that steps one sample through the shared multiply-accumulate unit.
// Depends on tfpb_pkg for the state enum and the control struct.
`timescale 1ns / 1ps

module tfpb_ctrl
   import tfpb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_free,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:          if (req_valid) state_in = ST_MUL_ACCEL;
         ST_MUL_ACCEL:     state_in = ST_MUL_GYRO;
         ST_MUL_GYRO:      state_in = ST_MUL_BLEND_ACC;
         ST_MUL_BLEND_ACC: state_in = ST_MUL_BLEND_GYR;
         ST_MUL_BLEND_GYR: state_in = ST_SUM_BLEND;
         ST_SUM_BLEND:     state_in = ST_ANGLE;
         ST_ANGLE:         state_in = ST_ERR;
         ST_ERR:           state_in = ST_MUL_PROP;
         ST_MUL_PROP:      state_in = ST_MUL_DERIV;
         ST_MUL_DERIV:     state_in = ST_SUM_DRIVE;
         ST_SUM_DRIVE:     state_in = ST_DRIVE;
         ST_DRIVE:         state_in = ST_DONE;
         ST_DONE:          if (out_free) state_in = ST_IDLE;
         default:          state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctrl          = '0;
      ctrl.mul_sel  = MS_ACCEL;
      ctrl.acc_op   = AO_HOLD;
      case (state_ff)
         ST_IDLE: begin
            ctrl.idle = 1'b1;
         end
         ST_MUL_ACCEL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_ACCEL;
         end
         ST_MUL_GYRO: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = MS_GYRO;
            ctrl.ld_accel = 1'b1;
         end
         ST_MUL_BLEND_ACC: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_BLEND_ACC;
            ctrl.ld_gyro = 1'b1;
         end
         ST_MUL_BLEND_GYR: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_BLEND_GYR;
            ctrl.acc_op  = AO_LOAD;
         end
         ST_SUM_BLEND: begin
            ctrl.acc_op = AO_ADD;
         end
         ST_ANGLE: begin
            ctrl.ld_angle = 1'b1;
         end
         ST_ERR: begin
            ctrl.ld_err = 1'b1;
         end
         ST_MUL_PROP: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_PROP;
            ctrl.ld_diff = 1'b1;
         end
         ST_MUL_DERIV: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MS_DERIV;
            ctrl.acc_op  = AO_LOAD;
         end
         ST_SUM_DRIVE: begin
            ctrl.acc_op = AO_ADD;
         end
         ST_DRIVE: begin
            ctrl.ld_drive = 1'b1;
         end
         ST_DONE: begin
            ctrl.ld_out = out_free;
         end
         default: begin
            ctrl.idle = 1'b0;
         end
      endcase
   end

endmodule

[hw/rtl/tilt_filter_pd_balance.sv]
// Tilt filter and PD balance drive. One word at a time: req_stall stays high from an accepted
// req word until the sequencer is back in idle, having stepped the six products through the
// single shared multiplier and its accumulator.
// A new req word is taken while a finished rsp word still waits in the output register.
// Synchronous reset restores register defaults and clears the kept angle and error.
// Depends on tfpb_pkg, tfpb_mac and tfpb_ctrl.
`timescale 1ns / 1ps

module tilt_filter_pd_balance
   import tfpb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_accel_raw,
   input  logic signed [15:0]     req_gyro_raw,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_left_speed,
   output logic signed [31:0]     rsp_right_speed,
   output logic signed [31:0]     rsp_angle_estimate,
   output logic                   rsp_in_band,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_type ctrl;
   logic     accept;
   logic     out_free;

   // configuration registers
   logic [15:0]        blend_weight_ff;
   logic signed [31:0] setpoint_angle_ff;
   logic [30:0]        tolerance_band_ff;
   logic [23:0]        prop_gain_ff;
   logic [23:0]        deriv_gain_ff;
   logic [23:0]        accel_gain_ff;
   logic [23:0]        gyro_gain_ff;

   // kept state
   logic signed [31:0] tilt_angle_ff;
   logic signed [31:0] last_error_ff;

   // per-sample working registers
   logic signed [15:0] accel_raw_ff;
   logic signed [15:0] gyro_raw_ff;
   logic signed [23:0] accel_tilt_ff, accel_tilt_in;
   logic signed [32:0] gyro_sum_ff, gyro_sum_in;
   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [32:0] diff_ff, diff_in;
   logic               band_ff, band_in;
   logic signed [31:0] drive_ff, drive_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] left_ff, right_ff, angle_out_ff;
   logic               in_band_ff;
   logic signed [31:0] right_in;

   // shared unit
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   acc;

   logic [16:0]        accel_weight;
   logic signed [32:0] err_wide;
   logic [32:0]        err_mag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctrl.idle;
   assign accept    = req_valid && ctrl.idle;
   assign csr_ready = 1'b1;

   tfpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   tfpb_mac u_mac (
      .clock  (clock),
      .mul_en (ctrl.mul_en),
      .acc_op (ctrl.acc_op),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod),
      .acc    (acc)
   );

   // accel path weight is 65536 - w, which needs 17 bits
   assign accel_weight = 17'h10000 - {1'b0, blend_weight_ff};

   always_comb begin
      case (ctrl.mul_sel)
         MS_ACCEL: begin
            op_a = {{(MUL_A_W-16){accel_raw_ff[15]}}, accel_raw_ff};
            op_b = {1'b0, accel_gain_ff};
         end
         MS_GYRO: begin
            op_a = {{(MUL_A_W-16){gyro_raw_ff[15]}}, gyro_raw_ff};
            op_b = {1'b0, gyro_gain_ff};
         end
         MS_BLEND_ACC: begin
            op_a = {{(MUL_A_W-24){accel_tilt_ff[23]}}, accel_tilt_ff};
            op_b = {{(MUL_B_W-17){1'b0}}, accel_weight};
         end
         MS_BLEND_GYR: begin
            op_a = {{(MUL_A_W-33){gyro_sum_ff[32]}}, gyro_sum_ff};
            op_b = {{(MUL_B_W-16){1'b0}}, blend_weight_ff};
         end
         MS_PROP: begin
            op_a = {{(MUL_A_W-32){err_ff[31]}}, err_ff};
            op_b = {1'b0, prop_gain_ff};
         end
         MS_DERIV: begin
            op_a = {{(MUL_A_W-33){diff_ff[32]}}, diff_ff};
            op_b = {1'b0, deriv_gain_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // floor(x * gain / 2^16) is just bits [39:16] of the product
   assign accel_tilt_in = prod[39:16];
   assign gyro_sum_in   = {{9{prod[39]}}, prod[39:16]} + {tilt_angle_ff[31], tilt_angle_ff};

   assign angle_in = sat32({{20{acc[ACC_W-1]}}, acc[ACC_W-1:16]});
   assign err_wide = {setpoint_angle_ff[31], setpoint_angle_ff} - {angle_ff[31], angle_ff};
   assign err_in   = sat32({{31{err_wide[32]}}, err_wide});
   assign diff_in  = {err_ff[31], err_ff} - {last_error_ff[31], last_error_ff};
   assign err_mag  = err_ff[31] ? 33'd0 - {err_ff[31], err_ff} : {1'b0, err_ff};
   assign band_in  = err_mag <= {2'b00, tolerance_band_ff};
   assign drive_in = band_ff ? 32'sd0 : sat32({{12{acc[ACC_W-1]}}, acc[ACC_W-1:8]});
   assign right_in = (drive_ff == I32_MIN) ? I32_MAX : 32'sd0 - drive_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         accel_raw_ff <= req_accel_raw;
         gyro_raw_ff  <= req_gyro_raw;
      end
      if (ctrl.ld_accel) accel_tilt_ff <= accel_tilt_in;
      if (ctrl.ld_gyro)  gyro_sum_ff   <= gyro_sum_in;
      if (ctrl.ld_angle) angle_ff      <= angle_in;
      if (ctrl.ld_err)   err_ff        <= err_in;
      if (ctrl.ld_diff) begin
         diff_ff <= diff_in;
         band_ff <= band_in;
      end
      if (ctrl.ld_drive) drive_ff <= drive_in;
      if (ctrl.ld_out) begin
         left_ff      <= drive_ff;
         right_ff     <= right_in;
         angle_out_ff <= angle_ff;
         in_band_ff   <= band_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (ctrl.ld_out)                rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         tilt_angle_ff     <= '0;
         last_error_ff     <= '0;
         blend_weight_ff   <= RST_BLEND_WEIGHT;
         setpoint_angle_ff <= RST_SETPOINT_ANGLE;
         tolerance_band_ff <= RST_TOLERANCE_BAND;
         prop_gain_ff      <= RST_PROP_GAIN;
         deriv_gain_ff     <= RST_DERIV_GAIN;
         accel_gain_ff     <= RST_ACCEL_GAIN;
         gyro_gain_ff      <= RST_GYRO_GAIN;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.ld_out) begin
            tilt_angle_ff <= angle_ff;
            last_error_ff <= err_ff;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BLEND_WEIGHT:   blend_weight_ff   <= csr_wdata[15:0];
               REG_SETPOINT_ANGLE: setpoint_angle_ff <= csr_wdata;
               REG_TOLERANCE_BAND: tolerance_band_ff <= csr_wdata[30:0];
               REG_PROP_GAIN:      prop_gain_ff      <= csr_wdata[23:0];
               REG_DERIV_GAIN:     deriv_gain_ff     <= csr_wdata[23:0];
               REG_ACCEL_GAIN:     accel_gain_ff     <= csr_wdata[23:0];
               REG_GYRO_GAIN:      gyro_gain_ff      <= csr_wdata[23:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_speed     = left_ff;
   assign rsp_right_speed    = right_ff;
   assign rsp_angle_estimate = angle_out_ff;
   assign rsp_in_band        = in_band_ff;

endmodule
